[design/wrms_pkg.sv]
// Shared types and constants for the windowed RMS column block.
`timescale 1ns / 1ps
package wrms_pkg;

  localparam int unsigned SumW = 48;
  localparam int unsigned RowW = 15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_HDIV,
    ST_LANE,
    ST_OUT
  } wrms_state_t;

  typedef enum logic [2:0] {
    CFG_STEREO    = 3'd0,
    CFG_WIDE      = 3'd1,
    CFG_WINDOW    = 3'd2,
    CFG_HEIGHT    = 3'd3,
    CFG_COUNT     = 3'd4
  } wrms_cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the sample on the input port
    logic div_start;  // load sum / window divider
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic hdiv_start; // load height * rms into the divider
    logic hdiv_step;
    logic lane_store; // store geometry for the current lane
    logic lane_sel;   // 0 left, 1 right
    logic close;      // clear sums as the result is loaded
    logic out_load;
  } wrms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic window_done;
    logic finished;
    logic step_last;
    logic stereo;
  } wrms_stat_t;

endpackage

[design/wrms_ctrl.sv]
// Sequencer for accumulate, divide, root and geometry steps.
`timescale 1ns / 1ps
module wrms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_busy,
  input  wrms_pkg::wrms_stat_t stat,
  output wrms_pkg::wrms_cmd_t  cmd
);
  import wrms_pkg::*;

  wrms_state_t state_r, state_nxt;
  logic        lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lane_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    unique case (state_r)
      ST_IDLE: begin
        lane_nxt = 1'b0;
        if (in_valid && stat.window_done && !stat.finished) state_nxt = ST_DIV;
      end
      ST_DIV:  if (stat.step_last) state_nxt = ST_SQRT;
      ST_SQRT: if (stat.step_last) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_HDIV;
      ST_HDIV: if (stat.step_last) state_nxt = ST_LANE;
      ST_LANE: begin
        if (stat.stereo && !lane_r) begin
          lane_nxt  = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT:  if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    cmd.lane_sel = lane_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        cmd.div_start = in_valid && stat.window_done && !stat.finished;
      end
      ST_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.sqrt_start = stat.step_last;
      end
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_MUL:  cmd.hdiv_start = 1'b1;
      ST_HDIV: cmd.hdiv_step = 1'b1;
      ST_LANE: begin
        cmd.lane_store = 1'b1;
        cmd.div_start  = stat.stereo && !lane_r;
        cmd.lane_sel   = lane_r;
      end
      ST_OUT: begin
        cmd.out_load = !out_busy;
        cmd.close    = !out_busy;
      end
      default: ;
    endcase
  end
endmodule

[design/wrms_dpath.sv]
// Accumulators, shared serial divider, square root and column geometry.
`timescale 1ns / 1ps
module wrms_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_stereo,
  input  logic                cfg_wide,
  input  logic [15:0]         cfg_window,
  input  logic [11:0]         cfg_height,
  input  logic [15:0]         cfg_count,
  input  logic signed [15:0]  in_sample,
  input  wrms_pkg::wrms_cmd_t  cmd,
  output wrms_pkg::wrms_stat_t stat,
  output logic [15:0]         col_idx,
  output logic signed [14:0]  l_top,
  output logic signed [14:0]  l_bot,
  output logic                l_stub,
  output logic signed [14:0]  r_top,
  output logic signed [14:0]  r_bot,
  output logic                r_stub
);
  import wrms_pkg::*;

  logic [SumW-1:0] lsum_r, rsum_r;
  logic [16:0]     cnt_r;
  logic            phase_r;
  logic [15:0]     done_r;

  logic [16:0] win;
  logic signed [15:0] val;
  logic [31:0] sq;
  logic        frame_end;
  logic [16:0] cnt_inc;
  logic        finished;

  assign win      = (cfg_window == 16'd0) ? 17'd1 : {1'b0, cfg_window};
  assign finished = ({1'b0, done_r} >= {1'b0, cfg_count});
  assign val      = cfg_wide ? in_sample : {8'd0, in_sample[7:0]};
  assign sq       = 32'($signed(val) * $signed(val));
  assign frame_end = !cfg_stereo || phase_r;
  assign cnt_inc  = (cnt_r == 17'h1FFFF) ? cnt_r : cnt_r + 17'd1;

  // Shared restoring divider: quotient over 48 steps, remainder 17 bits.
  logic [SumW-1:0] q_r;
  logic [17:0]     rem_r;
  logic [16:0]     dvs_r;
  logic [5:0]      step_r;
  logic [17:0]     rem_sh;
  logic            ge;

  // Square root: 24 steps of two bits.
  logic [SumW-1:0] x_r;
  logic [25:0]     sr_r;
  logic [23:0]     root_r;
  logic [25:0]     sr_sh, trial;

  logic [35:0]     prod;
  logic [15:0]     fs;

  always_comb begin
    if (cfg_stereo) fs = cfg_wide ? 16'h7F00 : 16'h007F;
    else            fs = cfg_wide ? 16'h3F00 : 16'h003F;
  end

  assign rem_sh = {rem_r[16:0], q_r[SumW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign sr_sh  = {sr_r[23:0], x_r[SumW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign prod   = 36'(cfg_height) * 36'(root_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // in mono the closing sample is still being added to the left sum
      q_r    <= cmd.lane_sel ^ (cmd.lane_store) ? rsum_r :
                (cfg_stereo ? lsum_r : lsum_r + SumW'(sq));
      rem_r  <= '0;
      dvs_r  <= win;
      step_r <= 6'(SumW - 1);
    end else if (cmd.div_step) begin
      q_r    <= {q_r[SumW-2:0], ge};
      rem_r  <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      step_r <= cmd.sqrt_start ? 6'(SumW / 2 - 1) : step_r - 6'd1;
    end else if (cmd.sqrt_start) begin
      step_r <= 6'(SumW / 2 - 1);
    end else if (cmd.sqrt_step) begin
      step_r <= step_r - 6'd1;
    end else if (cmd.hdiv_start) begin
      q_r    <= {12'd0, prod};
      rem_r  <= '0;
      dvs_r  <= {1'b0, fs};
      step_r <= 6'(SumW - 1);
    end else if (cmd.hdiv_step) begin
      q_r    <= {q_r[SumW-2:0], ge};
      rem_r  <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      step_r <= step_r - 6'd1;
    end
  end

  // quotient of the first divide, formed combinationally during its last step
  logic [SumW-1:0] quo_final;
  assign quo_final = {q_r[SumW-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      x_r    <= quo_final;
      sr_r   <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      x_r <= {x_r[SumW-3:0], 2'b00};
      if (sr_sh >= trial) begin
        sr_r   <= sr_sh - trial;
        root_r <= {root_r[22:0], 1'b1};
      end else begin
        sr_r   <= sr_sh;
        root_r <= {root_r[22:0], 1'b0};
      end
    end
  end

  assign stat.step_last   = (step_r == 6'd0);
  assign stat.finished    = finished;
  assign stat.stereo      = cfg_stereo;
  assign stat.window_done = frame_end && (cnt_inc >= win);

  // Lane geometry from the height quotient (q_r holds it after ST_HDIV).
  logic [15:0] h;
  logic [13:0] cen;
  logic signed [14:0] ctr, half, top, bot;
  logic        stub;
  assign h    = q_r[15:0];
  always_comb begin
    if (!cfg_stereo)      cen = 14'(cfg_height >> 1);
    else if (!cmd.lane_sel) cen = 14'(cfg_height >> 2);
    else                  cen = 14'((14'(cfg_height) * 14'd3) >> 2);
  end
  assign ctr  = {1'b0, cen};
  assign stub = (h <= 16'd1);
  assign half = 15'(h >> 1);
  assign top  = stub ? ctr : ctr - half;
  assign bot  = stub ? ctr : ctr + half;

  logic signed [14:0] lt_r, lb_r, rt_r, rb_r;
  logic lst_r, rst_r;

  always_ff @(posedge clk) begin
    if (cmd.lane_store && !cmd.lane_sel) begin
      lt_r <= top; lb_r <= bot; lst_r <= stub;
      rt_r <= '0;  rb_r <= '0;  rst_r <= 1'b0;
    end
    if (cmd.lane_store && cmd.lane_sel) begin
      rt_r <= top; rb_r <= bot; rst_r <= stub;
    end
  end

  assign col_idx = done_r;
  assign l_top = lt_r; assign l_bot = lb_r; assign l_stub = lst_r;
  assign r_top = rt_r; assign r_bot = rb_r; assign r_stub = rst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r  <= '0;
      rsum_r  <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      done_r  <= '0;
    end else if (cmd.close) begin
      lsum_r  <= '0;
      rsum_r  <= '0;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      done_r  <= done_r + 16'd1;
    end else if (cmd.accept && !finished) begin
      if (cfg_stereo && phase_r) begin
        rsum_r  <= rsum_r + SumW'(sq);
        phase_r <= 1'b0;
      end else begin
        lsum_r  <= lsum_r + SumW'(sq);
        phase_r <= cfg_stereo;
      end
      cnt_r <= cnt_inc;
    end
  end
endmodule

[design/windowed_rms_waveform_columns.sv]
// Top level of the windowed RMS column meter.
//
// Samples enter on in_sample with in_valid/in_stall, interleaved left and
// right in stereo mode. Each accepted sample is squared and added to its
// lane's sum. The sample that closes a window starts the back end: per
// lane a 48-step serial divide by the window, a 24-step square root, the
// ST_MUL state to load height * rms and a 48-step divide by full scale,
// plus the ST_LANE state to store the lane, one shared divider doing both
// divides. ST_OUT then loads the output register; in_stall stays high
// over the whole pass, through both lanes in stereo. A column is shown on
// out_* with out_valid and held while out_stall is high; sampling resumes
// meanwhile, and the next column waits in the back end until it is taken.
// Other samples do not stall the input. After column_count columns samples
// are accepted and dropped. Configuration goes in through cfg_valid/
// cfg_ready/cfg_index/cfg_data and is always ready; write it only while
// idle. Synchronous reset restores register defaults and clears sums and
// counters.
`timescale 1ns / 1ps
module windowed_rms_waveform_columns (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_column,
  output logic signed [14:0] out_left_top,
  output logic signed [14:0] out_left_bottom,
  output logic               out_left_stub,
  output logic signed [14:0] out_right_top,
  output logic signed [14:0] out_right_bottom,
  output logic               out_right_stub,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import wrms_pkg::*;

  logic        stereo_r, wide_r;
  logic [15:0] window_r, count_r;
  logic [11:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
      wide_r   <= 1'b1;
      window_r <= 16'd12250;
      height_r <= 12'd15;
      count_r  <= 16'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEREO: stereo_r <= cfg_data[0];
        CFG_WIDE:   wide_r   <= cfg_data[0];
        CFG_WINDOW: window_r <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data[11:0];
        CFG_COUNT:  count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  wrms_cmd_t  cmd;
  wrms_stat_t stat;
  logic       out_busy;
  logic [15:0] col;
  logic signed [14:0] lt, lb, rt, rb;
  logic ls, rs;

  assign out_busy = out_valid && out_stall;

  wrms_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_busy, .stat, .cmd
  );

  wrms_dpath u_dpath (
    .clk, .rst_n,
    .cfg_stereo(stereo_r), .cfg_wide(wide_r), .cfg_window(window_r),
    .cfg_height(height_r), .cfg_count(count_r),
    .in_sample, .cmd, .stat,
    .col_idx(col), .l_top(lt), .l_bot(lb), .l_stub(ls),
    .r_top(rt), .r_bot(rb), .r_stub(rs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_column       <= col;
      out_left_top     <= lt;
      out_left_bottom  <= lb;
      out_left_stub    <= ls;
      out_right_top    <= rt;
      out_right_bottom <= rb;
      out_right_stub   <= rs;
    end
  end
endmodule

[design/wrms_checker.sv]
// Port-level checks for the RMS column meter, bound to the top level.
`timescale 1ns / 1ps
module wrms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_column,
  input logic        out_left_stub,
  input logic signed [14:0] out_left_top,
  input logic signed [14:0] out_left_bottom
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_column))
    else $error("result dropped while stalled");

  // a new column only appears at the end of a back-end pass
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("column loaded while input was open");

  a_stub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_left_stub |-> out_left_top == out_left_bottom)
    else $error("stub column has a span");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid |-> out_column != $past(out_column))
    else $error("column repeated");
endmodule

bind windowed_rms_waveform_columns wrms_checker u_wrms_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_column,
  .out_left_stub, .out_left_top, .out_left_bottom
);
